### rtl/core/lpff_pkg.sv
// types, register indexes and fixed constants of the lidar point frame filter
`default_nettype none

package lpff_pkg;

   // one lidar point in sensor frame
   typedef struct packed {
      logic signed [15:0] point_x;
      logic signed [15:0] point_y;
      logic signed [15:0] point_z;
      logic               point_valid;
      logic               frame_last;
   } req_type;

   // one filtered point
   typedef struct packed {
      logic               kept;
      logic signed [15:0] world_x;
      logic signed [15:0] world_y;
      logic signed [15:0] world_z;
      logic        [15:0] depth;
      logic               scan_last;
   } rsp_type;

   // register indexes
   localparam int NUM_CSR   = 7;
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_SENSOR_ROW_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SENSOR_ROW_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SENSOR_ROW_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WORLD_ROW_X  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WORLD_ROW_Y  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_WORLD_ROW_Z  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMITS       = 3'd6;

   // reset values: identity rows, zero offsets, open limits
   localparam logic [63:0] ROW_X_RESET  = 64'h0000_0000_0000_4000;
   localparam logic [63:0] ROW_Y_RESET  = 64'h0000_0000_4000_0000;
   localparam logic [63:0] ROW_Z_RESET  = 64'h0000_4000_0000_0000;
   localparam logic [63:0] LIMITS_RESET = 64'h7FFF_8000_7FFF_7FFF;

   // rejection thresholds in cm
   localparam int NEAR_SENSOR_SQ = 42 * 42;
   localparam int NEAR_WORLD_SQ  = 45 * 45;
   localparam int BOX_HALF_XY    = 36;
   localparam int BOX_LOW_Z      = -16;
   localparam int BOX_HIGH_Z     = 28;

   // Q2.14 rounding offset
   localparam int Q14_HALF = 8192;

   // square root unit: body squared norm width and one result bit per stage
   localparam int SQ_W     = 38;
   localparam int SQ_STEPS = SQ_W / 2;

   // what travels beside the square root
   typedef struct packed {
      logic               keep;
      logic               last;
      logic signed [15:0] wx;
      logic signed [15:0] wy;
      logic signed [15:0] wz;
   } sq_tag_type;

   // pipeline control for the square root unit
   typedef struct packed {
      logic advance;
      logic valid;
   } sq_ctrl_type;

   // signed Q2.14 coefficient of one column of a rotation row
   function automatic logic signed [15:0] coef(input logic [63:0] row, input logic [1:0] col);
      coef = $signed(row[16*col +: 16]);
   endfunction

   // signed translation of a row
   function automatic logic signed [15:0] offset(input logic [63:0] row);
      offset = $signed(row[63:48]);
   endfunction

endpackage

`default_nettype wire

### rtl/core/lpff_isqrt.sv
// pipelined integer square root, one result bit per stage
`default_nettype none

module lpff_isqrt (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire lpff_pkg::sq_ctrl_type              ctrl,
   input  wire logic [lpff_pkg::SQ_W-1:0]          n_in,
   input  wire lpff_pkg::sq_tag_type               tag_in,
   output logic                                    out_valid,
   output logic [lpff_pkg::SQ_STEPS-1:0]           root,
   output lpff_pkg::sq_tag_type                    tag_out
);

   localparam int LAST = lpff_pkg::SQ_STEPS - 1;

   logic                         vld_ff [lpff_pkg::SQ_STEPS];
   logic [lpff_pkg::SQ_W-1:0]    res_ff [lpff_pkg::SQ_STEPS];
   logic [lpff_pkg::SQ_W-1:0]    rem_ff [lpff_pkg::SQ_STEPS-1];
   lpff_pkg::sq_tag_type         tag_ff [lpff_pkg::SQ_STEPS];

   for (genvar k = 0; k < lpff_pkg::SQ_STEPS; k++) begin : g_step
      localparam logic [lpff_pkg::SQ_W-1:0] STEP_BIT =
         lpff_pkg::SQ_W'(1) << (lpff_pkg::SQ_W - 2 - 2 * k);

      logic                       vld_prev;
      logic [lpff_pkg::SQ_W-1:0]  rem_prev;
      logic [lpff_pkg::SQ_W-1:0]  res_prev;
      lpff_pkg::sq_tag_type       tag_prev;
      logic [lpff_pkg::SQ_W:0]    trial;
      logic [lpff_pkg::SQ_W-1:0]  rem_in;
      logic [lpff_pkg::SQ_W-1:0]  res_in;

      // stage input from the port or from the stage before
      if (k == 0) begin : g_first
         assign vld_prev = ctrl.valid;
         assign rem_prev = n_in;
         assign res_prev = '0;
         assign tag_prev = tag_in;
      end else begin : g_next
         assign vld_prev = vld_ff[k-1];
         assign rem_prev = rem_ff[k-1];
         assign res_prev = res_ff[k-1];
         assign tag_prev = tag_ff[k-1];
      end

      // one trial subtraction
      always_comb begin
         trial = {1'b0, res_prev} + {1'b0, STEP_BIT};
         if ({1'b0, rem_prev} >= trial) begin
            rem_in = rem_prev - trial[lpff_pkg::SQ_W-1:0];
            res_in = (res_prev >> 1) + STEP_BIT;
         end else begin
            rem_in = rem_prev;
            res_in = res_prev >> 1;
         end
      end

      // valid bit
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (ctrl.advance) begin
            vld_ff[k] <= vld_prev;
         end
      end

      // payload
      always_ff @(posedge clock) begin
         if (ctrl.advance) begin
            res_ff[k] <= res_in;
            tag_ff[k] <= tag_prev;
         end
      end

      // remainder, not needed after the last bit
      if (k < LAST) begin : g_rem
         always_ff @(posedge clock) begin
            if (ctrl.advance) begin
               rem_ff[k] <= rem_in;
            end
         end
      end
   end

   assign out_valid = vld_ff[LAST];
   assign root      = res_ff[LAST][lpff_pkg::SQ_STEPS-1:0];
   assign tag_out   = tag_ff[LAST];

endmodule

`default_nettype wire

### rtl/core/lidar_point_frame_filter_top.sv
// top level of the lidar point crop and frame transform filter
// throughput: one point per cycle; the pipeline holds while a result waits
// the pipeline has 26 register stages (6 transform and test, 19 square root, 1 output)
// reset: valid bits clear, registers return to identity rows, zero offsets, open limits
`default_nettype none

module lidar_point_frame_filter_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire lpff_pkg::req_type                   req_payload,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output lpff_pkg::rsp_type                        rsp_payload,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [lpff_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [63:0]                         csr_wdata
);

   // saturate a world coordinate to 16 bits
   function automatic logic signed [15:0] sat16(input logic signed [21:0] v);
      if (v > 22'sd32767) begin
         sat16 = 16'sh7FFF;
      end else if (v < -22'sd32768) begin
         sat16 = 16'sh8000;
      end else begin
         sat16 = v[15:0];
      end
   endfunction

   logic advance;

   // configuration registers
   logic [63:0] cfg_ff [lpff_pkg::NUM_CSR];

   // no register write is taken while reset is high
   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff[lpff_pkg::CSR_SENSOR_ROW_X] <= lpff_pkg::ROW_X_RESET;
         cfg_ff[lpff_pkg::CSR_SENSOR_ROW_Y] <= lpff_pkg::ROW_Y_RESET;
         cfg_ff[lpff_pkg::CSR_SENSOR_ROW_Z] <= lpff_pkg::ROW_Z_RESET;
         cfg_ff[lpff_pkg::CSR_WORLD_ROW_X]  <= lpff_pkg::ROW_X_RESET;
         cfg_ff[lpff_pkg::CSR_WORLD_ROW_Y]  <= lpff_pkg::ROW_Y_RESET;
         cfg_ff[lpff_pkg::CSR_WORLD_ROW_Z]  <= lpff_pkg::ROW_Z_RESET;
         cfg_ff[lpff_pkg::CSR_LIMITS]       <= lpff_pkg::LIMITS_RESET;
      end else if (csr_valid && csr_ready &&
                   csr_index < lpff_pkg::CSR_IDX_W'(lpff_pkg::NUM_CSR)) begin
         cfg_ff[csr_index] <= csr_wdata;
      end
   end

   logic [15:0]        range_x, range_y;
   logic signed [15:0] ground, roof;

   assign range_x = cfg_ff[lpff_pkg::CSR_LIMITS][15:0];
   assign range_y = cfg_ff[lpff_pkg::CSR_LIMITS][31:16];
   assign ground  = $signed(cfg_ff[lpff_pkg::CSR_LIMITS][47:32]);
   assign roof    = $signed(cfg_ff[lpff_pkg::CSR_LIMITS][63:48]);

   // whole pipeline moves unless the output register is held; no request during reset
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance && !reset;

   // stage 1: range test, sensor rotation products, sensor squares
   logic signed [15:0] pt [3];
   logic [16:0]        abs_x, abs_y;
   logic               drop1_in;
   logic signed [31:0] prod1_in [3][3];
   logic signed [31:0] psq_full [3];
   logic [30:0]        psq_in [3];

   assign pt[0] = req_payload.point_x;
   assign pt[1] = req_payload.point_y;
   assign pt[2] = req_payload.point_z;

   always_comb begin
      abs_x = pt[0][15] ? 17'(-17'($signed(pt[0]))) : {1'b0, pt[0]};
      abs_y = pt[1][15] ? 17'(-17'($signed(pt[1]))) : {1'b0, pt[1]};
      drop1_in = !req_payload.point_valid ||
                 abs_x > {1'b0, range_x} || abs_y > {1'b0, range_y};
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            prod1_in[i][j] = 32'(lpff_pkg::coef(
                                cfg_ff[lpff_pkg::CSR_IDX_W'(lpff_pkg::CSR_SENSOR_ROW_X + i)],
                                2'(j)))
                             * 32'(pt[j]);
         end
         psq_full[i] = 32'(pt[i]) * 32'(pt[i]);
         psq_in[i]   = psq_full[i][30:0];
      end
   end

   logic               v1_ff, drop1_ff, last1_ff;
   logic signed [31:0] prod1_ff [3][3];
   logic [30:0]        psq_ff [3];

   // stage 2: sensor rounding and offset, near sensor test
   logic signed [33:0] acc1 [3];
   logic signed [19:0] b_in [3];
   logic [32:0]        psum;
   logic               drop2_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         acc1[i] = 34'(prod1_ff[i][0]) + 34'(prod1_ff[i][1]) + 34'(prod1_ff[i][2])
                   + 34'(lpff_pkg::Q14_HALF);
         b_in[i] = $signed(acc1[i][33:14])
                   + 20'(lpff_pkg::offset(
                        cfg_ff[lpff_pkg::CSR_IDX_W'(lpff_pkg::CSR_SENSOR_ROW_X + i)]));
      end
      psum = 33'(psq_ff[0]) + 33'(psq_ff[1]) + 33'(psq_ff[2]);
      drop2_in = drop1_ff || psum < 33'(lpff_pkg::NEAR_SENSOR_SQ);
   end

   logic               v2_ff, drop2_ff, last2_ff;
   logic signed [19:0] b_ff [3];

   // stage 3: platform box, world rotation products, body squares
   logic               in_box;
   logic               drop3_in;
   logic signed [35:0] prod2_in [3][3];
   logic signed [39:0] bsq_full [3];
   logic [35:0]        bsq_in [3];

   always_comb begin
      in_box = b_ff[0] > 20'(-lpff_pkg::BOX_HALF_XY) && b_ff[0] < 20'(lpff_pkg::BOX_HALF_XY) &&
               b_ff[1] > 20'(-lpff_pkg::BOX_HALF_XY) && b_ff[1] < 20'(lpff_pkg::BOX_HALF_XY) &&
               b_ff[2] > 20'(lpff_pkg::BOX_LOW_Z)    && b_ff[2] < 20'(lpff_pkg::BOX_HIGH_Z);
      drop3_in = drop2_ff || in_box;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            prod2_in[i][j] = 36'(lpff_pkg::coef(
                                cfg_ff[lpff_pkg::CSR_IDX_W'(lpff_pkg::CSR_WORLD_ROW_X + i)],
                                2'(j)))
                             * 36'(b_ff[j]);
         end
         bsq_full[i] = 40'(b_ff[i]) * 40'(b_ff[i]);
         bsq_in[i]   = bsq_full[i][35:0];
      end
   end

   logic               v3_ff, drop3_ff, last3_ff;
   logic signed [35:0] prod2_ff [3][3];
   logic [35:0]        bsq3_ff [3];

   // stage 4: world rounding and position, body squared norm
   logic signed [37:0]        acc2 [3];
   logic signed [21:0]        rot_in [3];
   logic signed [21:0]        w_in [3];
   logic [lpff_pkg::SQ_W-1:0] bsum_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         acc2[i] = 38'(prod2_ff[i][0]) + 38'(prod2_ff[i][1]) + 38'(prod2_ff[i][2])
                   + 38'(lpff_pkg::Q14_HALF);
         rot_in[i] = $signed(acc2[i][35:14]);
         w_in[i]   = rot_in[i]
                     + 22'(lpff_pkg::offset(
                          cfg_ff[lpff_pkg::CSR_IDX_W'(lpff_pkg::CSR_WORLD_ROW_X + i)]));
      end
      bsum_in = lpff_pkg::SQ_W'(bsq3_ff[0]) + lpff_pkg::SQ_W'(bsq3_ff[1])
                + lpff_pkg::SQ_W'(bsq3_ff[2]);
   end

   logic                      v4_ff, drop4_ff, last4_ff;
   logic signed [21:0]        rot_ff [3];
   logic signed [21:0]        w_ff [3];
   logic [lpff_pkg::SQ_W-1:0] bsum4_ff;

   // stage 5: height band, rotated squares, world saturation
   logic               drop5_in;
   logic signed [43:0] rsq_full [3];
   logic [40:0]        rsq_in [3];
   logic signed [15:0] ws_in [3];

   always_comb begin
      drop5_in = drop4_ff || w_ff[2] < 22'(ground) || w_ff[2] > 22'(roof);
      for (int i = 0; i < 3; i++) begin
         rsq_full[i] = 44'(rot_ff[i]) * 44'(rot_ff[i]);
         rsq_in[i]   = rsq_full[i][40:0];
         ws_in[i]    = sat16(w_ff[i]);
      end
   end

   logic                      v5_ff, drop5_ff, last5_ff;
   logic [40:0]               rsq_ff [3];
   logic signed [15:0]        ws_ff [3];
   logic [lpff_pkg::SQ_W-1:0] bsum5_ff;

   // stage 6: near world test
   logic [42:0]          rsum;
   lpff_pkg::sq_tag_type tag6_in;

   always_comb begin
      rsum = 43'(rsq_ff[0]) + 43'(rsq_ff[1]) + 43'(rsq_ff[2]);
      tag6_in.keep = !(drop5_ff || rsum < 43'(lpff_pkg::NEAR_WORLD_SQ));
      tag6_in.last = last5_ff;
      tag6_in.wx   = ws_ff[0];
      tag6_in.wy   = ws_ff[1];
      tag6_in.wz   = ws_ff[2];
   end

   logic                      v6_ff;
   lpff_pkg::sq_tag_type      tag6_ff;
   logic [lpff_pkg::SQ_W-1:0] bsum6_ff;

   // valid bits of stages 1 to 6
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   // payload of stages 1 to 6
   always_ff @(posedge clock) begin
      if (advance) begin
         drop1_ff <= drop1_in;
         last1_ff <= req_payload.frame_last;
         prod1_ff <= prod1_in;
         psq_ff   <= psq_in;

         drop2_ff <= drop2_in;
         last2_ff <= last1_ff;
         b_ff     <= b_in;

         drop3_ff <= drop3_in;
         last3_ff <= last2_ff;
         prod2_ff <= prod2_in;
         bsq3_ff  <= bsq_in;

         drop4_ff <= drop3_ff;
         last4_ff <= last3_ff;
         rot_ff   <= rot_in;
         w_ff     <= w_in;
         bsum4_ff <= bsum_in;

         drop5_ff <= drop5_in;
         last5_ff <= last4_ff;
         rsq_ff   <= rsq_in;
         ws_ff    <= ws_in;
         bsum5_ff <= bsum4_ff;

         tag6_ff  <= tag6_in;
         bsum6_ff <= bsum5_ff;
      end
   end

   // depth square root
   lpff_pkg::sq_ctrl_type          sq_ctrl;
   logic                           sq_valid;
   logic [lpff_pkg::SQ_STEPS-1:0]  sq_root;
   lpff_pkg::sq_tag_type           sq_tag;

   assign sq_ctrl.advance = advance;
   assign sq_ctrl.valid   = v6_ff;

   lpff_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (sq_ctrl),
      .n_in      (bsum6_ff),
      .tag_in    (tag6_ff),
      .out_valid (sq_valid),
      .root      (sq_root),
      .tag_out   (sq_tag)
   );

   // output register
   lpff_pkg::rsp_type rsp_in;
   lpff_pkg::rsp_type rsp_ff;
   logic              rsp_valid_ff;

   always_comb begin
      rsp_in.kept      = sq_tag.keep;
      rsp_in.scan_last = sq_tag.last;
      rsp_in.world_x   = sq_tag.keep ? sq_tag.wx : '0;
      rsp_in.world_y   = sq_tag.keep ? sq_tag.wy : '0;
      rsp_in.world_z   = sq_tag.keep ? sq_tag.wz : '0;
      if (!sq_tag.keep) begin
         rsp_in.depth = '0;
      end else if (sq_root > lpff_pkg::SQ_STEPS'(16'hFFFF)) begin
         rsp_in.depth = 16'hFFFF;
      end else begin
         rsp_in.depth = sq_root[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   // a rejected point leaves all coordinates and depth at zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.kept |->
         rsp_payload.world_x == 16'sd0 && rsp_payload.world_y == 16'sd0 &&
         rsp_payload.world_z == 16'sd0 && rsp_payload.depth == 16'd0)
      else $error("rejected point carries nonzero data");

   // a kept point lies inside the height band
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.kept |->
         rsp_payload.world_z >= ground && rsp_payload.world_z <= roof)
      else $error("kept point outside height band");

   // nothing comes out right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");
`endif

endmodule

`default_nettype wire
